[design/scar_pkg.sv]
// ----------------------------------------------------------------------------
// scar_pkg
// Shared types and constants for the shared-clock serial ADC reader.
// ----------------------------------------------------------------------------
package scar_pkg;

    // Converter array geometry.
    localparam int MAX_DEVICES = 8;
    localparam int DATA_BITS   = 24;
    localparam int LINE_W      = 8;
    localparam int DEV_IDX_W   = $clog2(MAX_DEVICES);
    localparam int COUNT_W     = 4;
    localparam int GAIN_W      = 2;
    localparam int PCNT_W      = 5;
    localparam int VALUE_W     = 25;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES  = 2'd1;

    // Input action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PULSE = 1'b1;

    // One finished readout: every accumulator, every readiness flag and the
    // number of results to emit.
    typedef struct packed {
        logic [MAX_DEVICES-1:0][DATA_BITS-1:0] acc;
        logic [MAX_DEVICES-1:0]                not_ready;
        logic [COUNT_W-1:0]                    count;
    } t_run;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/scar_if.sv]
// ----------------------------------------------------------------------------
// scar_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface scar_in_if;
    import scar_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [LINE_W-1:0] data_lines;

    modport source (output valid, output action, output data_lines, input ready);
    modport sink   (input valid, input action, input data_lines, output ready);
endinterface

interface scar_out_if;
    import scar_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [DEV_IDX_W-1:0]      device_index;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last;

    modport source (output valid, output device_index, output sample_value,
                    output last, input ready);
    modport sink   (input valid, input device_index, input sample_value,
                    input last, output ready);
endinterface

[design/shared_clock_adc_serial_reader.sv]
// ----------------------------------------------------------------------------
// shared_clock_adc_serial_reader
// Readout of up to eight 24-bit serial converters on one shared clock line.
// ----------------------------------------------------------------------------
// Input channel: each item is a start (action 0, data lines sample readiness)
// or one clock pulse (action 1, data lines carry one bit per device). Pulses
// while idle are dropped; a start while busy restarts the run.
// One item is taken every cycle while the queue has room. After 24 data pulses
// and 1 to 3 gain pulses the final pulse queues the run, and results follow on
// the output channel, one per cycle while the output is ready, device 0 first,
// with last set on the final device.
// A finished run is first written into the queue; its results are then loaded
// one at a time into the output register.
// Up to two finished runs wait in the queue; when it is full, input ready
// drops until the back part frees an entry, which also pauses the run in
// progress. A stalled output holds its result until it is taken.
// Configuration writes (device count, gain pulses) are taken on any cycle
// with the write enable high. Reset clears all runs, empties the queue and
// restores device count 1 and gain pulses 1.
// ----------------------------------------------------------------------------
module shared_clock_adc_serial_reader import scar_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    scar_in_if.sink               i_in,
    scar_out_if.source            o_out
);

    t_q_status q_status;
    t_run      push_run;
    t_run      head_run;
    logic      push;
    logic      pop;

    // Front part: shifting and run sequencing.
    scar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_run       (push_run)
    );

    // Queue of finished runs.
    scar_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_run    (push_run),
        .i_pop    (pop),
        .o_head   (head_run),
        .o_status (q_status)
    );

    // Back part: result emission.
    scar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_run),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

[design/scar_front.sv]
// ----------------------------------------------------------------------------
// scar_front
// Accepts start and pulse items, shifts the data bits of every converter and
// hands each finished readout to the queue.
// ----------------------------------------------------------------------------
module scar_front import scar_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    scar_in_if.sink               i_in,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output t_run                  o_run
);

    logic [MAX_DEVICES-1:0][DATA_BITS-1:0] r_acc, n_acc;
    logic [MAX_DEVICES-1:0]                r_nr, n_nr;
    logic [PCNT_W-1:0]                     r_pulse_count, n_pulse_count;
    logic                                  r_busy, n_busy;
    logic [COUNT_W-1:0]                    r_dev_count;
    logic [GAIN_W-1:0]                     r_gain;

    logic              accept;
    logic [PCNT_W-1:0] pulse_inc;
    logic [PCNT_W-1:0] total;
    logic              final_pulse;

    // A new item is taken whenever a finished run has room in the queue.
    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    // Run length: data bits plus gain pulses, where zero gain pulses act as one.
    assign pulse_inc   = r_pulse_count + PCNT_W'(1);
    assign total       = PCNT_W'(DATA_BITS) +
                         ((r_gain == '0) ? PCNT_W'(1) : PCNT_W'(r_gain));
    assign final_pulse = r_busy && (i_in.action == ACT_PULSE) && (pulse_inc >= total);

    // Shift and sequencing state.
    always_comb begin
        n_acc         = r_acc;
        n_nr          = r_nr;
        n_pulse_count = r_pulse_count;
        n_busy        = r_busy;
        if (accept) begin
            if (i_in.action == ACT_START) begin
                for (int j = 0; j < MAX_DEVICES; j++) begin
                    n_acc[j] = '0;
                    n_nr[j]  = (j < LINE_W) ? i_in.data_lines[j] : 1'b0;
                end
                n_pulse_count = '0;
                n_busy        = 1'b1;
            end else if (r_busy) begin
                if (r_pulse_count < PCNT_W'(DATA_BITS)) begin
                    for (int j = 0; j < MAX_DEVICES; j++) begin
                        n_acc[j] = {r_acc[j][DATA_BITS-2:0],
                                    (j < LINE_W) ? i_in.data_lines[j] : 1'b0};
                    end
                end
                n_pulse_count = pulse_inc;
                if (final_pulse) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    // Finished run goes to the queue with its device count clamped.
    always_comb begin
        o_push          = accept && final_pulse;
        o_run.acc       = n_acc;
        o_run.not_ready = r_nr;
        if (r_dev_count == '0) begin
            o_run.count = COUNT_W'(1);
        end else if (r_dev_count > COUNT_W'(MAX_DEVICES)) begin
            o_run.count = COUNT_W'(MAX_DEVICES);
        end else begin
            o_run.count = r_dev_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_nr          <= '0;
            r_pulse_count <= '0;
            r_busy        <= 1'b0;
            r_dev_count   <= COUNT_W'(1);
            r_gain        <= GAIN_W'(1);
        end else begin
            r_acc         <= n_acc;
            r_nr          <= n_nr;
            r_pulse_count <= n_pulse_count;
            r_busy        <= n_busy;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEVICE_COUNT: r_dev_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_GAIN_PULSES:  r_gain      <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[design/scar_queue.sv]
// ----------------------------------------------------------------------------
// scar_queue
// Two-entry queue of finished readouts between the front and back parts.
// ----------------------------------------------------------------------------
module scar_queue import scar_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_run      i_run,
    input  logic      i_pop,
    output t_run      o_head,
    output t_q_status o_status
);

    t_run       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    // Storage needs no reset; only the pointers and the count do.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/scar_back.sv]
// ----------------------------------------------------------------------------
// scar_back
// Walks the devices of the oldest queued readout and emits one result per
// cycle, while the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module scar_back import scar_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_run      i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    scar_out_if.source o_out
);

    localparam logic [DATA_BITS-1:0] FLIP = {1'b1, {(DATA_BITS-1){1'b0}}};

    logic                      r_valid;
    logic [DEV_IDX_W-1:0]      r_dev;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_last;
    logic [DEV_IDX_W-1:0]      r_idx;

    logic                      advance;
    logic                      take;
    logic                      is_last;
    logic signed [VALUE_W-1:0] value;

    // The output stage loads whenever it is empty or its result is taken.
    assign advance = !r_valid || o_out.ready;
    assign take    = advance && !i_q_status.empty;
    assign is_last = (COUNT_W'(r_idx) + COUNT_W'(1)) == i_head.count;
    assign o_pop   = take && is_last;

    // A device that was not ready reads as minus one.
    always_comb begin
        if (i_head.not_ready[r_idx]) begin
            value = '1;
        end else begin
            value = VALUE_W'({1'b0, i_head.acc[r_idx] ^ FLIP});
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.device_index = r_dev;
    assign o_out.sample_value = r_value;
    assign o_out.last         = r_last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dev   <= r_idx;
            r_value <= value;
            r_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? '0 : r_idx + DEV_IDX_W'(1);
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the shared-clock serial ADC reader. Start and
// pulse transfers are sent on the input channel. A readout predictor works out
// the readings each run should produce, and every result transfer is checked
// field by field against the oldest pending reading. Both channels idle at
// random, and the result side also holds off for a long stretch. Directed runs
// cover register extremes and the special cases. Random runs cover the rest.
// ----------------------------------------------------------------------------
module tb import scar_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 24;
    localparam int RANDOM_RESULTS = 1;
    localparam int HOLD_CYCLES    = 250;
    localparam int PRESSURE_RUNS  = 3;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [DATA_BITS-1:0] SIGN_FLIP = {1'b1, {(DATA_BITS-1){1'b0}}};

    typedef enum {PAT_RANDOM, PAT_ONES, PAT_ZEROS, PAT_ALT} t_line_pattern;

    typedef struct packed {
        logic [DEV_IDX_W-1:0]      dev;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_reading;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scar_in_if  in_ch ();
    scar_out_if out_ch ();

    shared_clock_adc_serial_reader u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state: a copy of the registers and of the run in progress.
    logic [DATA_BITS-1:0]   conv_acc [MAX_DEVICES];
    logic [MAX_DEVICES-1:0] conv_not_ready;
    int                     pulses_seen;
    bit                     readout_active;
    logic [COUNT_W-1:0]     dev_count_cfg;
    logic [GAIN_W-1:0]      gain_cfg;

    t_reading pending_readings [$];

    int  cycle_count;
    int  err_count;
    int  items_sent;
    int  ignored_pulses;
    int  runs_completed;
    int  results_predicted;
    int  results_checked;
    int  input_stall_cycles;
    int  hold_left;
    int  sink_gap_left;
    bit  src_idle_on;
    bit  sink_idle_on;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Gap lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LINE_W-1:0] rand_lines();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return LINE_W'($urandom_range(0, 255));
    endfunction

    function automatic int eff_gain();
        return (gain_cfg == 0) ? 1 : int'(gain_cfg);
    endfunction

    // Advance the readout predictor by one accepted transfer. Returns 0 for a
    // pulse that the block ignores because no run is active.
    function automatic bit predict_transfer(input logic act, input logic [LINE_W-1:0] lines);
        int       n;
        t_reading r;
        if (act == ACT_START) begin
            for (int j = 0; j < MAX_DEVICES; j++) begin
                conv_acc[j] = '0;
            end
            conv_not_ready = lines;
            pulses_seen    = 0;
            readout_active = 1'b1;
            return 1'b1;
        end
        if (!readout_active) begin
            return 1'b0;
        end
        // Data bits shift in MSB first; the gain pulses that follow shift nothing.
        if (pulses_seen < DATA_BITS) begin
            for (int j = 0; j < MAX_DEVICES; j++) begin
                conv_acc[j] = {conv_acc[j][DATA_BITS-2:0], lines[j]};
            end
        end
        pulses_seen++;
        if (pulses_seen < DATA_BITS + eff_gain()) begin
            return 1'b1;
        end
        // Final pulse: the device count in force now decides how many results.
        readout_active = 1'b0;
        runs_completed++;
        n = (dev_count_cfg == 0) ? 1 :
            (dev_count_cfg > MAX_DEVICES) ? MAX_DEVICES : int'(dev_count_cfg);
        for (int j = 0; j < n; j++) begin
            r.dev   = DEV_IDX_W'(j);
            r.value = conv_not_ready[j] ? {VALUE_W{1'b1}}
                                        : VALUE_W'(conv_acc[j] ^ SIGN_FLIP);
            r.last  = (j == n - 1);
            pending_readings.push_back(r);
            results_predicted++;
        end
        return 1'b1;
    endfunction

    // Send one item, waiting for its transfer. Valid stays high on return;
    // the caller sends again or releases the channel in the same step.
    task automatic send_item(input logic act, input logic [LINE_W-1:0] lines);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.data_lines <= lines;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (predict_transfer(act, lines)) begin
            items_sent++;
        end else begin
            ignored_pulses++;
        end
    endtask

    // A start transfer followed by a number of pulse transfers.
    task automatic send_run(input logic [LINE_W-1:0] ready_lines, input int pulses,
                            input t_line_pattern pat);
        logic [LINE_W-1:0] lines;
        send_item(ACT_START, ready_lines);
        for (int k = 0; k < pulses; k++) begin
            case (pat)
                PAT_ONES:  lines = '1;
                PAT_ZEROS: lines = '0;
                PAT_ALT:   lines = (k % 2 == 0) ? '1 : '0;
                default:   lines = rand_lines();
            endcase
            send_item(ACT_PULSE, lines);
        end
    endtask

    // Release the input channel, wait for every pending reading, then let the
    // block settle so that a register write finds it quiet.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers and the two undecoded indexes in one burst.
    task automatic apply_config(input logic [CFG_DATA_W-1:0] count,
                                input logic [GAIN_W-1:0] gain);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVICE_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        dev_count_cfg = count;
        i_cfg_index <= CFG_GAIN_PULSES;
        i_cfg_data  <= CFG_DATA_W'(gain);
        @(posedge i_clk);
        gain_cfg = gain;
        i_cfg_index <= CFG_SPARE_A;
        i_cfg_data  <= CFG_DATA_W'($urandom_range(0, 15));
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE_B;
        i_cfg_data  <= CFG_DATA_W'($urandom_range(0, 15));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: long hold-off first, then random gaps when enabled.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (sink_gap_left > 0) begin
                out_ch.ready <= 1'b0;
                sink_gap_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                    sink_gap_left = pick_gap();
                end
            end
        end
    end

    // Check every result transfer against the oldest pending reading.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && in_ch.valid && !in_ch.ready) begin
            input_stall_cycles++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_readings.size() == 0) begin
                $error("Result transfer with nothing pending: device_index %0d sample_value %0d",
                       out_ch.device_index, out_ch.sample_value);
                err_count++;
            end else begin
                want = pending_readings.pop_front();
                results_checked++;
                if (out_ch.device_index !== want.dev) begin
                    $error("device_index mismatch: expected %0d, actual %0d",
                           want.dev, out_ch.device_index);
                    err_count++;
                end
                if (out_ch.sample_value !== want.value) begin
                    $error("sample_value mismatch: expected %0d, actual %0d",
                           want.value, out_ch.sample_value);
                    err_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           want.last, out_ch.last);
                    err_count++;
                end
            end
        end
    end

    // Defaults after reset, a pulse with no run active, and alternating data.
    task automatic test_defaults();
        send_item(ACT_PULSE, '1);
        send_run('0, DATA_BITS + 1, PAT_ALT);
        drain();
    endtask

    // Out-of-range count and gain, the top gain, and a restart mid-run.
    task automatic test_register_extremes();
        apply_config(4'd15, 2'd0);
        send_run(8'h5A, DATA_BITS + 1, PAT_ZEROS);
        send_run(8'hFF, 5, PAT_ONES);
        drain();
        apply_config(4'd0, 2'd3);
        send_run(8'h00, DATA_BITS + 3, PAT_ONES);
        drain();
    endtask

    // Gain lowered and count changed while a run sits in its gain pulses.
    task automatic test_midrun_config();
        apply_config(4'd8, 2'd3);
        send_run(8'h81, DATA_BITS + 2, PAT_RANDOM);
        drain();
        apply_config(4'd4, 2'd1);
        send_item(ACT_PULSE, rand_lines());
        drain();
    endtask

    // Result side held off while full runs keep coming, so the queue fills.
    task automatic test_backpressure();
        apply_config(4'd8, 2'd2);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_left    = HOLD_CYCLES;
        for (int k = 0; k < PRESSURE_RUNS; k++) begin
            send_run(rand_lines(), DATA_BITS + 2, PAT_RANDOM);
        end
        drain();
    endtask

    // Mostly complete runs with random data, plus cut-short runs, stray
    // pulses and back-to-back starts.
    task automatic test_random();
        int base_items;
        int base_results;
        int phase;
        int r;
        logic [CFG_DATA_W-1:0] count;
        logic [GAIN_W-1:0]     gain;
        base_items   = items_sent;
        base_results = results_predicted;
        phase        = 0;
        while (items_sent - base_items < RANDOM_ITEMS ||
               results_predicted - base_results < RANDOM_RESULTS) begin
            case (phase)
                0: begin count = 4'd1;  gain = 2'd1; end
                1: begin count = 4'd8;  gain = 2'd3; end
                2: begin count = 4'd0;  gain = 2'd0; end
                3: begin count = 4'd15; gain = 2'd2; end
                default: begin
                    r     = $urandom_range(0, 3);
                    count = (r == 0) ? 4'd0 : (r == 1) ? CFG_DATA_W'($urandom_range(9, 15))
                                                       : CFG_DATA_W'($urandom_range(1, 8));
                    gain  = GAIN_W'($urandom_range(0, 3));
                end
            endcase
            apply_config(count, gain);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2)) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_run(($urandom_range(0, 1) == 0) ? '0 : rand_lines(),
                             DATA_BITS + eff_gain(), PAT_RANDOM);
                end else if (r < 82) begin
                    send_run(rand_lines(), $urandom_range(0, DATA_BITS + 2), PAT_RANDOM);
                end else if (r < 92) begin
                    repeat ($urandom_range(1, 3)) send_item(ACT_PULSE, rand_lines());
                end else begin
                    send_item(ACT_START, rand_lines());
                    send_run(rand_lines(), DATA_BITS + eff_gain(), PAT_RANDOM);
                end
            end
            drain();
            phase++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_DEVICE_COUNT;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_START;
        in_ch.data_lines = '0;
        cycle_count        = 0;
        err_count          = 0;
        items_sent         = 0;
        ignored_pulses     = 0;
        runs_completed     = 0;
        results_predicted  = 0;
        results_checked    = 0;
        input_stall_cycles = 0;
        hold_left          = 0;
        sink_gap_left      = 0;
        src_idle_on        = 1'b1;
        sink_idle_on       = 1'b1;
        for (int j = 0; j < MAX_DEVICES; j++) begin
            conv_acc[j] = '0;
        end
        conv_not_ready = '0;
        pulses_seen    = 0;
        readout_active = 1'b0;
        dev_count_cfg  = 4'd1;
        gain_cfg       = 2'd1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_register_extremes();
        test_midrun_config();
        test_backpressure();
        test_random();
        drain();

        $display("Sent %0d effective input transfers and %0d ignored pulses; %0d runs finished.",
                 items_sent, ignored_pulses, runs_completed);
        $display("Checked %0d readings; input was stalled for %0d cycles by backpressure.",
                 results_checked, input_stall_cycles);
        if (err_count == 0 && pending_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
